// ===== hdl/kmbt_pkg.sv =====
// shared types and constants for the keyed max bid table
package kmbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int USER_W            = 16;
    localparam int ITEM_W            = 16;
    localparam int AMOUNT_W          = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [USER_W-1:0]   user;
        logic [ITEM_W-1:0]   item;
        logic [AMOUNT_W-1:0] amount;
    } t_cmd;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_if;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_sts;

    typedef struct packed {
        logic                valid;
        logic [USER_W-1:0]   user;
        logic [ITEM_W-1:0]   item;
        logic [AMOUNT_W-1:0] amount;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== hdl/kmbt_ram.sv =====
// generic single write port ram with registered read
module kmbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kmbt_front.sv =====
// front end: takes input transactions, classifies them and queues commands
module kmbt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [kmbt_pkg::USER_W-1:0]    i_user_id,
    input  logic [kmbt_pkg::ITEM_W-1:0]    i_item_id,
    input  logic [kmbt_pkg::AMOUNT_W-1:0]  i_amount,
    input  kmbt_pkg::t_back_sts            i_sts,
    output kmbt_pkg::t_q_if                o_q
);
    import kmbt_pkg::*;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    t_cmd       cmd;
    logic       push;
    logic       pop;

    always_comb begin
        cmd.op     = t_op'(i_opcode);
        cmd.user   = i_user_id;
        cmd.item   = i_item_id;
        // amount only matters for add and update
        cmd.amount = (cmd.op == OP_ADD || cmd.op == OP_UPDATE) ? i_amount : '0;
    end

    assign o_stall = i_sts.clearing || (r_fill == QUEUE_DEPTH);
    assign push    = i_valid && !o_stall;
    assign pop     = i_sts.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= cmd;
        end
    end

    assign o_q.valid = (r_fill != 2'd0);
    assign o_q.cmd   = r_slot[r_rp];

endmodule

// ===== hdl/kmbt_back.sv =====
// back end: scans the bid table for each command and writes the result register
module kmbt_back #(
    parameter int ENTRIES = kmbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kmbt_pkg::t_q_if            i_q,
    output kmbt_pkg::t_back_sts        o_sts,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic                       o_found,
    output logic [kmbt_pkg::USER_W-1:0] o_winner_id
);
    import kmbt_pkg::*;

    localparam int             AW       = $clog2(ENTRIES);
    localparam logic [AW-1:0]  LAST_IDX = AW'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_didx, n_didx;
    t_cmd                r_cmd, n_cmd;
    logic                r_hit, n_hit;
    logic [AW-1:0]       r_hit_idx, n_hit_idx;
    logic                r_free_ok, n_free_ok;
    logic [AW-1:0]       r_free_idx, n_free_idx;
    logic                r_any, n_any;
    logic [AMOUNT_W-1:0] r_best_amt, n_best_amt;
    logic [USER_W-1:0]   r_best_user, n_best_user;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic                r_found, n_found;
    logic [USER_W-1:0]   r_winner, n_winner;

    logic               we;
    logic [AW-1:0]      waddr;
    t_entry             wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [ENTRY_W-1:0] rdata;
    t_entry             rd;
    t_entry             new_entry;
    logic               pop;

    kmbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd = t_entry'(rdata);

    always_comb begin
        new_entry.valid  = 1'b1;
        new_entry.user   = r_cmd.user;
        new_entry.item   = r_cmd.item;
        new_entry.amount = r_cmd.amount;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_cmd       = r_cmd;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_any       = r_any;
        n_best_amt  = r_best_amt;
        n_best_user = r_best_user;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_found     = r_found;
        n_winner    = r_winner;
        we          = 1'b0;
        waddr       = r_cnt;
        wdata       = '0;
        re          = 1'b0;
        raddr       = r_cnt;
        pop         = 1'b0;

        // look at the entry whose read was issued in the previous cycle
        if (r_dv) begin
            if (rd.valid && rd.user == r_cmd.user && rd.item == r_cmd.item && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_didx;
            end
            if (!rd.valid && !r_free_ok) begin
                n_free_ok  = 1'b1;
                n_free_idx = r_didx;
            end
            if (rd.valid && rd.item == r_cmd.item &&
                (!r_any || rd.amount > r_best_amt ||
                 (rd.amount == r_best_amt && rd.user > r_best_user))) begin
                n_any       = 1'b1;
                n_best_amt  = rd.amount;
                n_best_user = rd.user;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q.valid) begin
                    pop       = 1'b1;
                    n_cmd     = i_q.cmd;
                    n_cnt     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_any     = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                re     = 1'b1;
                raddr  = r_cnt;
                n_dv   = 1'b1;
                n_didx = r_cnt;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // table write and result go together once the output slot frees up
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_found     = 1'b0;
                    n_winner    = '0;
                    n_state     = S_IDLE;
                    unique case (r_cmd.op)
                        OP_ADD: begin
                            if (r_hit) begin
                                we    = 1'b1;
                                waddr = r_hit_idx;
                                wdata = new_entry;
                            end else if (r_free_ok) begin
                                we    = 1'b1;
                                waddr = r_free_idx;
                                wdata = new_entry;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_UPDATE: begin
                            if (r_hit) begin
                                we    = 1'b1;
                                waddr = r_hit_idx;
                                wdata = new_entry;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                we    = 1'b1;
                                waddr = r_hit_idx;
                                wdata = '0;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_QUERY: begin
                            if (r_any) begin
                                n_found  = 1'b1;
                                n_winner = r_best_user;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx      <= n_didx;
        r_cmd       <= n_cmd;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_free_ok   <= n_free_ok;
        r_free_idx  <= n_free_idx;
        r_any       <= n_any;
        r_best_amt  <= n_best_amt;
        r_best_user <= n_best_user;
        r_status    <= n_status;
        r_found     <= n_found;
        r_winner    <= n_winner;
    end

    assign o_sts.clearing = (r_state == S_CLEAR);
    assign o_sts.pop      = pop;
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_winner_id    = r_winner;

endmodule

// ===== hdl/keyed_max_bid_table.sv =====
// top level of the keyed max bid table
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_opcode, i_user_id, i_item_id, i_amount
//  result    out        o_valid / i_stall  o_status, o_found, o_winner_id
//
// each transaction runs through the back end in steps: it takes the command, reads the
// table ram once per entry, then drains the last read and finally writes back and posts
// the result
// after reset a clearing pass writes every entry invalid, with o_stall high
// a two-deep command queue lets input transactions land while the back end scans
// a stalled result holds the back end in its final step until taken
module keyed_max_bid_table #(
    parameter int TABLE_ENTRIES = kmbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [kmbt_pkg::USER_W-1:0]   i_user_id,
    input  logic [kmbt_pkg::ITEM_W-1:0]   i_item_id,
    input  logic [kmbt_pkg::AMOUNT_W-1:0] i_amount,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic [kmbt_pkg::USER_W-1:0]   o_winner_id
);
    import kmbt_pkg::*;

    t_q_if     q;
    t_back_sts sts;

    kmbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .i_user_id (i_user_id),
        .i_item_id (i_item_id),
        .i_amount  (i_amount),
        .i_sts     (sts),
        .o_q       (q)
    );

    kmbt_back #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_winner_id (o_winner_id)
    );

endmodule

// ===== hdl/kmbt_checker.sv =====
// port level checks for the keyed max bid table, bound to the top level
module kmbt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [1:0]                    o_status,
    input logic                          o_found,
    input logic [kmbt_pkg::USER_W-1:0]   o_winner_id
);
    import kmbt_pkg::*;

    logic [2:0] r_pending;

    // transactions taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {2'b00, i_valid && !o_stall} - {2'b00, o_valid && !i_stall};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_found)
            && $stable(o_winner_id))
        else $error("stalled result changed");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == ST_OK)
        else $error("found result without ok status");

    a_no_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_winner_id == '0)
        else $error("winner reported without a find");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 3'd0)
        else $error("result without an accepted transaction");

    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled during clearing pass");

endmodule

bind keyed_max_bid_table kmbt_checker u_kmbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_found     (o_found),
    .o_winner_id (o_winner_id)
);
